>>> rtl/assert_macros.svh
// Assertion helpers for the query builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/dqb_pkg.sv
package dqb_pkg;

    localparam int MAX_LABEL_DEF = 32;

    localparam logic [7:0] CHAR_DOT = 8'd46;
    localparam logic [7:0] CHAR_END = 8'd0;

    localparam logic [3:0] HDR_LEN  = 4'd12;
    localparam logic [3:0] TAIL_LEN = 4'd5;

    localparam logic [3:0] HDR_ID_HI      = 4'd0;
    localparam logic [3:0] HDR_ID_LO      = 4'd1;
    localparam logic [3:0] HDR_FLAGS_HI   = 4'd2;
    localparam logic [3:0] HDR_QDCOUNT_LO = 4'd5;

    localparam logic [3:0] TAIL_TYPE_HI  = 4'd1;
    localparam logic [3:0] TAIL_TYPE_LO  = 4'd2;
    localparam logic [3:0] TAIL_CLASS_HI = 4'd3;
    localparam logic [3:0] TAIL_CLASS_LO = 4'd4;

    localparam logic CFG_QUERY_TYPE  = 1'b0;
    localparam logic CFG_QUERY_CLASS = 1'b1;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } t_emit;

    typedef struct packed {
        logic busy;
        logic ovf;
    } t_stat;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
        logic [7:0] b;
        case (idx)
            HDR_ID_HI:      b = id[15:8];
            HDR_ID_LO:      b = id[7:0];
            HDR_FLAGS_HI:   b = 8'h01;
            HDR_QDCOUNT_LO: b = 8'h01;
            default:        b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [3:0] idx, input logic [15:0] qtype,
                                             input logic [15:0] qclass);
        logic [7:0] b;
        case (idx)
            TAIL_TYPE_HI:  b = qtype[15:8];
            TAIL_TYPE_LO:  b = qtype[7:0];
            TAIL_CLASS_HI: b = qclass[15:8];
            TAIL_CLASS_LO: b = qclass[7:0];
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/dqb_in_if.sv
interface dqb_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  name_byte;
    logic [15:0] query_id;

    modport source (output valid, output name_byte, output query_id, input ready);
    modport sink   (input valid, input name_byte, input query_id, output ready);
endinterface

>>> rtl/dqb_out_if.sv
interface dqb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       label_overflow;

    modport source (output valid, output out_byte, output out_last, output label_overflow,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input label_overflow,
                    output ready);
endinterface

>>> rtl/dqb_ram.sv
module dqb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dqb_pkg::MAX_LABEL_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dqb_seq.sv
module dqb_seq #(
    parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF,
    localparam int FILL_W = $clog2(MAX_LABEL + 1),
    localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [7:0]        i_byte,
    input  logic [15:0]       i_id,
    input  logic [15:0]       i_qtype,
    input  logic [15:0]       i_qclass,
    input  logic              i_load_ok,
    output dqb_pkg::t_emit    o_emit,
    output dqb_pkg::t_stat    o_stat,
    output logic [FILL_W-1:0] o_fill,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic [7:0]        o_wdata,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [7:0]        i_rdata
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_HDR  = 7'b0000010,
        S_DISP = 7'b0000100,
        S_LEN  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_DAT  = 7'b0100000,
        S_TAIL = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [3:0]        r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_rd, n_rd;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_hs, n_hs;
    logic              r_ovf, n_ovf;
    logic [7:0]        r_byte, n_byte;
    logic [15:0]       r_id, n_id;
    logic              w_sep;

    assign w_sep = (r_byte == dqb_pkg::CHAR_DOT) || (r_byte == dqb_pkg::CHAR_END);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rd    = r_rd;
        n_fill  = r_fill;
        n_hs    = r_hs;
        n_ovf   = r_ovf;
        n_byte  = r_byte;
        n_id    = r_id;
        o_emit  = '0;
        o_we    = 1'b0;
        o_re    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_byte  = i_byte;
                    n_id    = i_id;
                    n_cnt   = '0;
                    n_state = r_hs ? S_DISP : S_HDR;
                end
            end
            S_HDR: begin
                if (i_load_ok) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = dqb_pkg::hdr_byte(r_cnt, r_id);
                    if (r_cnt == dqb_pkg::HDR_LEN - 4'd1) begin
                        n_hs    = 1'b1;
                        n_fill  = '0;
                        n_state = S_DISP;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            S_DISP: begin
                n_cnt = '0;
                n_rd  = '0;
                if (w_sep) begin
                    if (r_fill != '0) begin
                        n_state = S_LEN;
                    end else if (r_byte == dqb_pkg::CHAR_END) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_fill < FILL_W'(MAX_LABEL)) begin
                        o_we   = 1'b1;
                        n_fill = r_fill + FILL_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_LEN: begin
                if (i_load_ok) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = 8'(r_fill);
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                o_re    = 1'b1;
                n_state = S_DAT;
            end
            S_DAT: begin
                if (i_load_ok) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = i_rdata;
                    if (FILL_W'(r_rd) + FILL_W'(1) == r_fill) begin
                        n_fill  = '0;
                        n_state = (r_byte == dqb_pkg::CHAR_END) ? S_TAIL : S_IDLE;
                    end else begin
                        n_rd    = r_rd + ADDR_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_TAIL: begin
                if (i_load_ok) begin
                    o_emit.valid = 1'b1;
                    o_emit.data  = dqb_pkg::tail_byte(r_cnt, i_qtype, i_qclass);
                    if (r_cnt == dqb_pkg::TAIL_LEN - 4'd1) begin
                        o_emit.last = 1'b1;
                        n_hs        = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_fill  <= '0;
            r_hs    <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
            r_fill  <= n_fill;
            r_hs    <= n_hs;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_id   <= n_id;
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.ovf  = r_ovf;
    assign o_fill      = r_fill;
    assign o_waddr     = r_fill[ADDR_W-1:0];
    assign o_wdata     = r_byte;
    assign o_raddr     = r_rd;

endmodule

>>> rtl/dns_query_builder_top.sv
// channel   dir  word fields                             handshake
// i_in      in   name_byte[7:0], query_id[15:0]          valid/ready
// o_out     out  out_byte[7:0], out_last, label_overflow valid/ready
// cfg       in   i_cfg_idx (0 type, 1 class), i_cfg_data write on i_cfg_we
// An input word that only buffers a character goes through dispatch back to idle; the
// first word of a name also emits the 12-byte header. A flush emits the length byte, then
// each stored character (label RAM read, data byte), then the 5-byte tail on the end byte.
// Input ready is high only while the sequencer is idle; output stalls hold its emit states.
// Synchronous active-low reset; no clearing pass, type and class reset to 1.
`include "assert_macros.svh"
module dns_query_builder_top #(
    parameter int MAX_LABEL = dqb_pkg::MAX_LABEL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqb_in_if.sink      i_in,
    dqb_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    localparam int FILL_W = $clog2(MAX_LABEL + 1);
    localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    dqb_pkg::t_emit    w_emit;
    dqb_pkg::t_stat    w_stat;
    logic [FILL_W-1:0] w_fill;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_rdata;
    logic              w_start;
    logic              w_load_ok;

    logic [15:0] r_qtype;
    logic [15:0] r_qclass;
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_ol;
    logic        r_oo;

    assign i_in.ready = !w_stat.busy;
    assign w_start    = i_in.valid && !w_stat.busy;
    assign w_load_ok  = !r_ov || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtype  <= 16'd1;
            r_qclass <= 16'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dqb_pkg::CFG_QUERY_TYPE:  r_qtype  <= i_cfg_data;
                dqb_pkg::CFG_QUERY_CLASS: r_qclass <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dqb_seq #(
        .MAX_LABEL(MAX_LABEL)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_byte   (i_in.name_byte),
        .i_id     (i_in.query_id),
        .i_qtype  (r_qtype),
        .i_qclass (r_qclass),
        .i_load_ok(w_load_ok),
        .o_emit   (w_emit),
        .o_stat   (w_stat),
        .o_fill   (w_fill),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata),
        .o_re     (w_re),
        .o_raddr  (w_raddr),
        .i_rdata  (w_rdata)
    );

    dqb_ram #(
        .WIDTH(8),
        .DEPTH(MAX_LABEL)
    ) u_label_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_emit.valid) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_ob <= w_emit.data;
            r_ol <= w_emit.last;
            r_oo <= w_stat.ovf;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.out_byte       = r_ob;
    assign o_out.out_last       = r_ol;
    assign o_out.label_overflow = r_oo;

    `ASSERT_IMP(a_fill_max, i_clk, i_rst_n, 1'b1, w_fill <= FILL_W'(MAX_LABEL))
    `ASSERT_NXT(a_ovf_sticky, i_clk, i_rst_n, w_stat.ovf, w_stat.ovf)
    `ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `ASSERT_NXT(a_last_idle, i_clk, i_rst_n, w_emit.valid && w_emit.last, !w_stat.busy)

endmodule
